// File: rtl/altk_pkg.sv
// Shared types, token codes and character classes for the arithmetic language tokenizer.
package altk_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int START_W = 16;
	localparam int LEN_W = 16;
	localparam int KIND_W = 4;
	localparam int TDATA_W = 40;

	localparam logic [KIND_W-1:0] K_ADD    = 4'd0;
	localparam logic [KIND_W-1:0] K_SUB    = 4'd1;
	localparam logic [KIND_W-1:0] K_MUL    = 4'd2;
	localparam logic [KIND_W-1:0] K_DIV    = 4'd3;
	localparam logic [KIND_W-1:0] K_ASSIGN = 4'd4;
	localparam logic [KIND_W-1:0] K_EQ     = 4'd5;
	localparam logic [KIND_W-1:0] K_GT     = 4'd6;
	localparam logic [KIND_W-1:0] K_GTE    = 4'd7;
	localparam logic [KIND_W-1:0] K_LT     = 4'd8;
	localparam logic [KIND_W-1:0] K_LTE    = 4'd9;
	localparam logic [KIND_W-1:0] K_LET    = 4'd10;
	localparam logic [KIND_W-1:0] K_INT    = 4'd11;
	localparam logic [KIND_W-1:0] K_ID     = 4'd12;
	localparam logic [KIND_W-1:0] K_ERR    = 4'd13;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               final_tok;
	} tok_t;

	// Results caused by one item: count of 0, 1 or 2 and the tokens in order.
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       t0;
		tok_t       t1;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

// File: rtl/altk_scan.sv
// Scanner: mode, pending token and position registers with the per-item token logic.
module altk_scan #(
	parameter int POSITION_BITS = altk_pkg::POSITION_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      char_code,
	input  logic            end_of_source,
	output altk_pkg::res_t  res
);

	typedef enum logic [2:0] {
		M_IDLE, M_EQ, M_GT, M_LT, M_INT, M_ID
	} mode_t;

	mode_t                          mode_q, mode_n;
	logic [altk_pkg::START_W-1:0]   start_q, start_n;
	logic [altk_pkg::LEN_W-1:0]     len_q, len_n;
	logic [POSITION_BITS-1:0]       pos_q, pos_n;
	logic [1:0]                     kp_q, kp_n;

	function automatic logic [altk_pkg::LEN_W-1:0] grow(input logic [altk_pkg::LEN_W-1:0] l);
		return (&l) ? l : l + 1'b1;
	endfunction

	always_comb begin
		logic                          used;
		logic [1:0]                    n;
		altk_pkg::tok_t                t0, t1, e;
		logic [altk_pkg::START_W-1:0]  pos16;
		logic                          alnum;

		used  = 1'b0;
		n     = 2'd0;
		t0    = '0;
		t1    = '0;
		e     = '0;
		pos16 = altk_pkg::START_W'(pos_q);
		alnum = altk_pkg::is_digit(char_code) || altk_pkg::is_alpha(char_code);
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		kp_n    = kp_q;

		// First slot: the pending token is continued or closed.
		unique case (mode_q) inside
			M_EQ, M_GT, M_LT: begin
				e.start = start_q;
				if (char_code == altk_pkg::CH_EQ) begin
					e.kind = (mode_q == M_EQ) ? altk_pkg::K_EQ :
						(mode_q == M_GT) ? altk_pkg::K_GTE : altk_pkg::K_LTE;
					e.len = altk_pkg::LEN_W'(2);
					used  = 1'b1;
				end else begin
					e.kind = (mode_q == M_EQ) ? altk_pkg::K_ASSIGN :
						(mode_q == M_GT) ? altk_pkg::K_GT : altk_pkg::K_LT;
					e.len = altk_pkg::LEN_W'(1);
					kp_n  = 2'd0;
				end
				t0     = e;
				n      = 2'd1;
				mode_n = M_IDLE;
				len_n  = '0;
			end
			M_INT: begin
				if (altk_pkg::is_digit(char_code)) begin
					len_n = grow(len_q);
					used  = 1'b1;
				end else begin
					t0.kind  = altk_pkg::K_INT;
					t0.start = start_q;
					t0.len   = len_q;
					n        = 2'd1;
					mode_n   = M_IDLE;
					kp_n     = 2'd0;
					len_n    = '0;
				end
			end
			M_ID: begin
				if (alnum) begin
					if (kp_q == 2'd2 && char_code == altk_pkg::CH_T) begin
						t0.kind  = altk_pkg::K_LET;
						t0.start = start_q;
						t0.len   = altk_pkg::LEN_W'(3);
						n        = 2'd1;
						mode_n   = M_IDLE;
						kp_n     = 2'd0;
						len_n    = '0;
					end else begin
						kp_n  = (kp_q == 2'd1 && char_code == altk_pkg::CH_E) ? 2'd2 : 2'd0;
						len_n = grow(len_q);
					end
					used = 1'b1;
				end else begin
					t0.kind  = altk_pkg::K_ID;
					t0.start = start_q;
					t0.len   = len_q;
					n        = 2'd1;
					mode_n   = M_IDLE;
					kp_n     = 2'd0;
					len_n    = '0;
				end
			end
			default: mode_n = M_IDLE;
		endcase

		// A character not taken by the pending token starts something new.
		e       = '0;
		e.start = pos16;
		e.len   = altk_pkg::LEN_W'(1);
		if (!used && !altk_pkg::is_space(char_code)) begin
			if (char_code == altk_pkg::CH_PLUS || char_code == altk_pkg::CH_MINUS ||
				char_code == altk_pkg::CH_STAR || char_code == altk_pkg::CH_SLASH ||
				!(alnum || char_code == altk_pkg::CH_EQ || char_code == altk_pkg::CH_GT ||
				char_code == altk_pkg::CH_LT)) begin
				unique case (char_code)
					altk_pkg::CH_PLUS:  e.kind = altk_pkg::K_ADD;
					altk_pkg::CH_MINUS: e.kind = altk_pkg::K_SUB;
					altk_pkg::CH_STAR:  e.kind = altk_pkg::K_MUL;
					altk_pkg::CH_SLASH: e.kind = altk_pkg::K_DIV;
					default:            e.kind = altk_pkg::K_ERR;
				endcase
				if (n == 2'd0) t0 = e; else t1 = e;
				n = n + 2'd1;
			end else begin
				start_n = pos16;
				len_n   = altk_pkg::LEN_W'(1);
				if (char_code == altk_pkg::CH_EQ)      mode_n = M_EQ;
				else if (char_code == altk_pkg::CH_GT) mode_n = M_GT;
				else if (char_code == altk_pkg::CH_LT) mode_n = M_LT;
				else if (altk_pkg::is_digit(char_code)) mode_n = M_INT;
				else begin
					mode_n = M_ID;
					kp_n   = (char_code == altk_pkg::CH_L) ? 2'd1 : 2'd0;
				end
			end
		end

		// End of source flushes whatever is still pending.
		if (end_of_source) begin
			e       = '0;
			e.start = start_n;
			e.len   = altk_pkg::LEN_W'(1);
			if (mode_n != M_IDLE) begin
				unique case (mode_n)
					M_EQ:    e.kind = altk_pkg::K_ASSIGN;
					M_GT:    e.kind = altk_pkg::K_GT;
					M_LT:    e.kind = altk_pkg::K_LT;
					M_INT: begin
						e.kind = altk_pkg::K_INT;
						e.len  = len_n;
					end
					default: begin
						e.kind = altk_pkg::K_ID;
						e.len  = len_n;
					end
				endcase
				if (n == 2'd0) t0 = e; else t1 = e;
				n = n + 2'd1;
			end
			mode_n = M_IDLE;
			kp_n   = 2'd0;
			len_n  = '0;
			pos_n  = '0;
		end else begin
			pos_n = pos_q + 1'b1;
		end

		t0.final_tok = (n == 2'd1);
		t1.final_tok = 1'b1;
		res.cnt = n;
		res.t0  = t0;
		res.t1  = t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			kp_q    <= 2'd0;
		end else if (accept) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			len_q   <= len_n;
			pos_q   <= pos_n;
			kp_q    <= kp_n;
		end
	end

endmodule

// File: rtl/altk_obuf.sv
// Result register: holds an item's one or two tokens; hands out one per cycle on m_tready.
module altk_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  altk_pkg::res_t  res,
	output logic            space,
	output logic            m_tvalid,
	input  logic            m_tready,
	output altk_pkg::tok_t  head
);

	logic [1:0]     cnt_q;
	altk_pkg::tok_t b0_q, b1_q;
	logic           pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign head     = b0_q;
	// Room for a new item once the last held token leaves in this cycle.
	assign space    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && res.cnt != 2'd0) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && res.cnt != 2'd0) begin
			b0_q <= res.t0;
			b1_q <= res.t1;
		end else if (pop) begin
			b0_q <= b1_q;
		end
	end

endmodule

// File: rtl/arith_language_tokenizer.sv
// Top level of the arithmetic language tokenizer: character stream in, token stream out.
//
//  channel   dir  tdata                                   tlast          tuser
//  s_axis    in   [7:0] char_code                         end_of_source  -
//  m_axis    out  [3:0] kind, [19:4] start, [35:20] len   final_token    -
//
// One character is accepted per cycle while s_tready is high; its tokens sit in the result
// register in the next cycle; an item with two tokens stalls input until the second leaves.
// The mode, pending token and position registers are updated when a character is accepted.
// Reset clears the mode to idle and the position to zero; a stalled output holds its token.
module arith_language_tokenizer #(
	parameter int POSITION_BITS = altk_pkg::POSITION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] char_code
	input  logic                         s_tlast,   // end_of_source
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [altk_pkg::TDATA_W-1:0] m_tdata,   // token_kind, token_start, token_length, pad
	output logic                         m_tlast    // final_token
);

	logic           accept;
	altk_pkg::res_t res;
	altk_pkg::tok_t head;

	assign accept = s_tvalid && s_tready;

	altk_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_code     (s_tdata),
		.end_of_source (s_tlast),
		.res           (res)
	);

	altk_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.res      (res),
		.space    (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {4'd0, head.len, head.start, head.kind};
	assign m_tlast = head.final_tok;

endmodule

// File: rtl/altk_chk.sv
// Port checker for the tokenizer, bound to the top level.
module altk_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [altk_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tlast
);

	logic [3:0]  kind;
	logic [15:0] len;

	assign kind = m_tdata[3:0];
	assign len  = m_tdata[35:20];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled token changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> kind <= altk_pkg::K_ERR && len != 16'd0)
		else $error("bad token kind or zero length");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind <= altk_pkg::K_DIV || kind == altk_pkg::K_ERR ||
		kind == altk_pkg::K_ASSIGN || kind == altk_pkg::K_GT || kind == altk_pkg::K_LT)
		|-> len == 16'd1)
		else $error("one-character token with wrong length");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == altk_pkg::K_EQ || kind == altk_pkg::K_GTE ||
		kind == altk_pkg::K_LTE) |-> len == 16'd2)
		else $error("two-character operator with wrong length");

	a_let: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == altk_pkg::K_LET |-> len == 16'd3)
		else $error("keyword with wrong length");

endmodule

bind arith_language_tokenizer altk_chk u_altk_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
